/* sv/sha_pkg.sv */
// Package with SHA-256 constants, round functions and shared types.
`default_nettype none
package sha_pkg;

   typedef enum logic [1:0] {
      CMD_ABSORB = 2'd0,
      CMD_ABSORB_FINISH = 2'd1,
      CMD_FINISH = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef logic [31:0] word_type;

   // Round constant table.
   function automatic word_type round_k(input logic [5:0] t);
      word_type k;
      case (t)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type start_hash(input logic [2:0] i);
      word_type h;
      case (i)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab;
         default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic word_type ror32(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sig1(input word_type x);
      return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type big0(input word_type x);
      return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
   endfunction

   function automatic word_type big1(input word_type x);
      return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
   endfunction

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;

   // Request from the byte front end to the compression core.
   typedef struct packed {
      logic start;
      logic bank;
   } core_req_type;

endpackage
`default_nettype wire

/* sv/sha256_stream_hasher.sv */
// Top level of the SHA-256 byte stream hasher.
// Usage:
//  - req channel: one byte per handshake (req_valid high, req_stall low) with
//    req_command (absorb, absorb+finish, finish) and req_data_byte.
//    Command 3 is dropped.
//  - rsp channel: eight digest words H0..H7 per finished message with
//    rsp_word_index and rsp_last_word on the eighth.
//  - Bytes enter at one per cycle into a two-bank block memory. A full block
//    starts a 64-round compression, one round per cycle followed by a
//    feed-forward step; a second full block arriving while the core is busy
//    stalls the input until the core frees a bank.
//  - Finish feeds the padding bytes one per cycle while no block is pending
//    (up to 72 bytes, followed by one or two compressions), then emits the
//    eight words, one per cycle when rsp_stall is low. The input stays stalled
//    until the last digest word is taken.
//  - Synchronous active-high reset loads the initial hash and clears counts.
//  - A stalled response holds its word and index.
`default_nettype none
module sha256_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);
   import sha_pkg::*;

   typedef enum logic [3:0] {
      ST_BYTES = 4'b0001,
      ST_PAD = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_OUT = 4'b1000
   } state_type;

   state_type st_ff, st_in;
   logic [5:0] fill_ff, fill_in;
   logic bank_ff, bank_in;
   logic [60:0] count_ff, count_in;
   logic [63:0] bits_ff;
   logic [2:0] idx_ff, idx_in;
   logic rv_ff, rv_in;
   logic pend_ff, pend_in;
   // padding sequencing flags
   logic pad_first_ff, pad_done_ff;

   logic wr_en;
   logic [7:0] wr_data;
   logic [3:0] rd_addr;
   logic rd_bank;
   logic [31:0] rd_data;
   logic core_busy;
   logic new_msg;
   core_req_type creq;
   logic accept, has_byte, do_finish;
   logic [2:0] len_sel;

   sha_buffer u_buf (
      .clock(clock), .wr_en(wr_en), .wr_bank(bank_ff), .wr_addr(fill_ff),
      .wr_data(wr_data), .rd_bank(rd_bank), .rd_addr(rd_addr), .rd_data(rd_data)
   );

   sha_core u_core (
      .clock(clock), .reset(reset), .req(creq), .new_msg(new_msg),
      .buf_word_addr(rd_addr), .buf_bank(rd_bank), .buf_word(rd_data),
      .busy(core_busy), .hash_index(idx_ff), .hash_word(rsp_digest_word)
   );

   // pend: a full block waits for the core
   assign req_stall = (st_ff != ST_BYTES) || pend_ff;
   assign accept = req_valid && !req_stall;
   assign has_byte = accept && (req_command == CMD_ABSORB || req_command == CMD_ABSORB_FINISH);
   assign do_finish = accept && (req_command == CMD_ABSORB_FINISH || req_command == CMD_FINISH);
   assign len_sel = 3'(fill_ff - LEN_START);

   always_comb begin
      st_in = st_ff;
      fill_in = fill_ff;
      bank_in = bank_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      rv_in = rv_ff;
      pend_in = pend_ff;
      wr_en = 1'b0;
      wr_data = req_data_byte;
      creq.start = 1'b0;
      creq.bank = bank_ff;
      new_msg = 1'b0;
      // hand a pending block to the core once it is free
      if (pend_ff && !core_busy) begin
         creq.start = 1'b1;
         creq.bank = ~bank_ff;
         pend_in = 1'b0;
      end
      case (st_ff)
         ST_BYTES: begin
            if (has_byte) begin
               wr_en = 1'b1;
               count_in = count_ff + 61'd1;
            end
            if (do_finish) st_in = ST_PAD;
         end
         ST_PAD: begin
            if (!pend_ff) begin
               wr_en = 1'b1;
               // length bytes go out most significant first
               if (pad_done_ff) wr_data = bits_ff[{~len_sel, 3'b000} +: 8];
               else if (pad_first_ff) wr_data = PAD_BYTE;
               else wr_data = 8'h00;
            end
         end
         ST_WAIT: begin
            if (!core_busy && !pend_ff) begin
               st_in = ST_OUT;
               rv_in = 1'b1;
               idx_in = '0;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  rv_in = 1'b0;
                  st_in = ST_BYTES;
                  new_msg = 1'b1;
                  count_in = '0;
               end
            end
         end
         default: st_in = ST_BYTES;
      endcase
      if (wr_en) begin
         fill_in = fill_ff + 6'd1;
         if (fill_ff == 6'd63) begin
            bank_in = ~bank_ff;
            if (core_busy && !creq.start) pend_in = 1'b1;
            else if (!creq.start) begin
               creq.start = 1'b1;
               creq.bank = bank_ff;
            end else pend_in = 1'b1;
         end
         if (st_ff == ST_PAD && pad_done_ff && fill_ff == 6'd63) st_in = ST_WAIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_BYTES;
         fill_ff <= '0;
         bank_ff <= 1'b0;
         count_ff <= '0;
         idx_ff <= '0;
         rv_ff <= 1'b0;
         pend_ff <= 1'b0;
         pad_first_ff <= 1'b0;
         pad_done_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         count_ff <= count_in;
         idx_ff <= idx_in;
         rv_ff <= rv_in;
         pend_ff <= pend_in;
         if (st_ff == ST_BYTES && do_finish) begin
            pad_first_ff <= 1'b1;
            pad_done_ff <= 1'b0;
         end else if (st_ff == ST_PAD && wr_en) begin
            pad_first_ff <= 1'b0;
            // length field starts once fill reaches 56 after the marker
            if (fill_in == LEN_START) pad_done_ff <= 1'b1;
         end
      end
      if (st_ff == ST_BYTES && do_finish) bits_ff <= {count_in, 3'b000};
   end

   assign rsp_valid = rv_ff;
   assign rsp_word_index = idx_ff;
   assign rsp_last_word = (idx_ff == 3'd7);

`ifndef SYNTH
   a_no_accept_in_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted during digest output");
   a_out_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_word |=> rsp_valid
         && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest index did not advance");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word_index))
      else $error("stalled response changed");
`endif
endmodule
`default_nettype wire

/* sv/sha_core.sv */
// SHA-256 compression core: schedule and working state over 64 rounds.
`default_nettype none
module sha_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sha_pkg::core_req_type req,
   input  wire logic              new_msg,
   output logic [3:0]             buf_word_addr,
   output logic                   buf_bank,
   input  wire logic [31:0]       buf_word,
   output logic                   busy,
   input  wire logic [2:0]        hash_index,
   output logic [31:0]            hash_word
);
   import sha_pkg::*;

   // schedule window: last 16 words
   word_type w_ff [16];
   word_type v_ff [8];
   word_type v_in [8];
   word_type h_ff [8];
   logic [6:0] t_ff, t_in;
   logic run_ff, run_in;
   logic fin_ff, fin_in;
   logic bank_ff;
   word_type w_cur, t1, t2, w_new;

   assign busy = run_ff | fin_ff;
   assign buf_bank = run_ff ? bank_ff : req.bank;
   // prefetch the word for the next round (the memory read is registered)
   assign buf_word_addr = run_ff ? (t_ff[3:0] + 4'd1) : 4'd0;
   assign hash_word = h_ff[hash_index];

   always_comb begin
      w_new = w_ff[0] + sig0(w_ff[1]) + w_ff[9] + sig1(w_ff[14]);
      w_cur = (t_ff < 7'd16) ? buf_word : w_new;
      t1 = v_ff[7] + big1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + round_k(t_ff[5:0]) + w_cur;
      t2 = big0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      v_in[0] = t1 + t2;
      v_in[1] = v_ff[0];
      v_in[2] = v_ff[1];
      v_in[3] = v_ff[2];
      v_in[4] = v_ff[3] + t1;
      v_in[5] = v_ff[4];
      v_in[6] = v_ff[5];
      v_in[7] = v_ff[6];
      run_in = run_ff;
      fin_in = 1'b0;
      t_in = t_ff;
      if (run_ff) begin
         t_in = t_ff + 7'd1;
         if (t_ff == 7'd63) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (req.start) begin
         run_in = 1'b1;
         t_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
         t_ff <= '0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
         t_ff <= t_in;
      end
      if (!run_ff && req.start) begin
         bank_ff <= req.bank;
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end
      if (run_ff) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= v_in[i];
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= w_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || new_msg) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= start_hash(3'(i));
      end else if (fin_ff) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      end
   end

`ifndef SYNTH
   a_fin_after_last: assert property (@(posedge clock) disable iff (reset)
      run_ff && t_ff == 7'd63 |=> fin_ff && !run_ff)
      else $error("finish did not follow last round");
   a_fin_single: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> !fin_ff)
      else $error("double finish");
   a_t_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> t_ff < 7'd64)
      else $error("round count out of range");
`endif
endmodule
`default_nettype wire

/* sv/sha_buffer.sv */
// Double-buffered block memory: byte writes, 32-bit big-endian word reads.
`default_nettype none
module sha_buffer (
   input  wire logic       clock,
   input  wire logic       wr_en,
   input  wire logic       wr_bank,
   input  wire logic [5:0] wr_addr,
   input  wire logic [7:0] wr_data,
   input  wire logic       rd_bank,
   input  wire logic [3:0] rd_addr,
   output logic [31:0]     rd_data
);
   // four byte lanes, each 2 banks x 16 words
   logic [7:0] lane0 [32];
   logic [7:0] lane1 [32];
   logic [7:0] lane2 [32];
   logic [7:0] lane3 [32];
   logic [4:0] waddr;
   logic [4:0] raddr;

   assign waddr = {wr_bank, wr_addr[5:2]};
   assign raddr = {rd_bank, rd_addr};

   always_ff @(posedge clock) begin
      if (wr_en && wr_addr[1:0] == 2'd0) lane0[waddr] <= wr_data;
      if (wr_en && wr_addr[1:0] == 2'd1) lane1[waddr] <= wr_data;
      if (wr_en && wr_addr[1:0] == 2'd2) lane2[waddr] <= wr_data;
      if (wr_en && wr_addr[1:0] == 2'd3) lane3[waddr] <= wr_data;
      rd_data <= {lane0[raddr], lane1[raddr], lane2[raddr], lane3[raddr]};
   end
endmodule
`default_nettype wire
